### hdl/ipv4p_pkg.sv
// shared types and constants of the ipv4 dotted text parser
package ipv4p_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_IGNORE = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  // outcome of one character, from the parse core to the result register
  typedef struct packed {
    logic        fire;
    logic        ok;
    logic [31:0] value;
  } result_t;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_LX    = 8'h78;

  localparam logic [32:0] ACC_SAT         = 33'h1_0000_0000;
  localparam logic [32:0] LIMIT_ONE_PART  = 33'h0_FFFF_FFFF;
  localparam logic [32:0] LIMIT_TWO_PART  = 33'h0_00FF_FFFF;
  localparam logic [32:0] LIMIT_THREE_PART = 33'h0_0000_FFFF;
  localparam logic [32:0] LIMIT_FOUR_PART = 33'h0_0000_00FF;

endpackage

### hdl/ipv4p_parse_core.sv
// parse state and per-character next-state logic of the ipv4 text parser
module ipv4p_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          ch,
  output ipv4p_pkg::result_t  res
);

  ipv4p_pkg::phase_t phase, phase_next;
  ipv4p_pkg::base_t  base, base_next;
  logic [32:0]       acc, acc_next;
  logic [1:0]        parts_done, parts_done_next;
  logic [7:0]        leading_parts [3];
  logic              error_seen, error_seen_next;
  logic              lp_we;

  always_comb begin
    logic              dig;
    logic              hex_letter;
    logic              is_sp;
    logic              in_part;
    logic              finish_now;
    logic              force_bad;
    logic              over;
    logic              ok;
    logic [3:0]        digit;
    logic [36:0]       prod;
    logic [31:0]       value;
    ipv4p_pkg::base_t  eff_base;

    phase_next      = phase;
    base_next       = base;
    acc_next        = acc;
    parts_done_next = parts_done;
    error_seen_next = error_seen;
    lp_we           = 1'b0;
    in_part         = 1'b0;
    finish_now      = 1'b0;
    force_bad       = 1'b0;
    eff_base        = base;

    dig   = (ch >= ipv4p_pkg::CHAR_0) && (ch <= ipv4p_pkg::CHAR_9);
    is_sp = (ch == ipv4p_pkg::CHAR_SPACE) ||
            ((ch >= ipv4p_pkg::CHAR_TAB) && (ch <= ipv4p_pkg::CHAR_CR));
    // letters a-f / A-F have low nibble 1..6
    digit = dig ? ch[3:0] : ch[3:0] + 4'd9;

    unique case (phase)
      ipv4p_pkg::PH_START: begin
        if (!dig) begin
          phase_next      = ipv4p_pkg::PH_ERROR;
          error_seen_next = 1'b1;
          if (ch == ipv4p_pkg::CHAR_NUL) begin
            finish_now = 1'b1;
            force_bad  = 1'b1;
          end
        end else begin
          acc_next = '0;
          if (ch == ipv4p_pkg::CHAR_0) begin
            phase_next = ipv4p_pkg::PH_ZERO;
          end else begin
            base_next  = ipv4p_pkg::BASE_DEC;
            acc_next   = {29'd0, ch[3:0]};
            phase_next = ipv4p_pkg::PH_DIGITS;
          end
        end
      end
      ipv4p_pkg::PH_ZERO: begin
        phase_next = ipv4p_pkg::PH_DIGITS;
        if ((ch == ipv4p_pkg::CHAR_LX) || (ch == ipv4p_pkg::CHAR_UX)) begin
          base_next = ipv4p_pkg::BASE_HEX;
        end else begin
          base_next = ipv4p_pkg::BASE_OCT;
          eff_base  = ipv4p_pkg::BASE_OCT;
          in_part   = 1'b1;
        end
      end
      ipv4p_pkg::PH_DIGITS: begin
        in_part = 1'b1;
      end
      default: begin
        // trailing text, error, or an unused phase code
        if (ch == ipv4p_pkg::CHAR_NUL) begin
          finish_now = 1'b1;
        end
      end
    endcase

    hex_letter = (eff_base == ipv4p_pkg::BASE_HEX) &&
                 (((ch >= ipv4p_pkg::CHAR_LA) && (ch <= ipv4p_pkg::CHAR_LF)) ||
                  ((ch >= ipv4p_pkg::CHAR_UA) && (ch <= ipv4p_pkg::CHAR_UF)));

    // shift-and-add multiply by the base, then add the digit
    unique case (eff_base)
      ipv4p_pkg::BASE_OCT: prod = {1'b0, acc, 3'b000};
      ipv4p_pkg::BASE_HEX: prod = {acc, 4'b0000};
      default:             prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    endcase
    prod = prod + {33'd0, digit};

    if (in_part) begin
      priority if (dig || hex_letter) begin
        acc_next = (prod[36:32] != 5'd0) ? ipv4p_pkg::ACC_SAT : prod[32:0];
      end else if (ch == ipv4p_pkg::CHAR_DOT) begin
        if ((parts_done == 2'd3) || (acc > ipv4p_pkg::LIMIT_FOUR_PART)) begin
          phase_next      = ipv4p_pkg::PH_ERROR;
          error_seen_next = 1'b1;
        end else begin
          lp_we           = 1'b1;
          parts_done_next = parts_done + 2'd1;
          acc_next        = '0;
          base_next       = ipv4p_pkg::BASE_DEC;
          phase_next      = ipv4p_pkg::PH_START;
        end
      end else if (ch == ipv4p_pkg::CHAR_NUL) begin
        finish_now = 1'b1;
      end else if (is_sp) begin
        phase_next = ipv4p_pkg::PH_IGNORE;
      end else begin
        phase_next      = ipv4p_pkg::PH_ERROR;
        error_seen_next = 1'b1;
      end
    end

    // last part limit depends on how many leading parts were stored
    unique case (parts_done)
      2'd0:    over = acc > ipv4p_pkg::LIMIT_ONE_PART;
      2'd1:    over = acc > ipv4p_pkg::LIMIT_TWO_PART;
      2'd2:    over = acc > ipv4p_pkg::LIMIT_THREE_PART;
      default: over = acc > ipv4p_pkg::LIMIT_FOUR_PART;
    endcase

    ok = !force_bad && !error_seen && (phase != ipv4p_pkg::PH_ERROR) && !over;

    value = acc[31:0];
    if (parts_done >= 2'd1) value = value | {leading_parts[0], 24'd0};
    if (parts_done >= 2'd2) value = value | {8'd0, leading_parts[1], 16'd0};
    if (parts_done >= 2'd3) value = value | {16'd0, leading_parts[2], 8'd0};

    if (finish_now) begin
      phase_next      = ipv4p_pkg::PH_START;
      base_next       = ipv4p_pkg::BASE_DEC;
      acc_next        = '0;
      parts_done_next = 2'd0;
      error_seen_next = 1'b0;
      lp_we           = 1'b0;
    end

    res.fire  = finish_now;
    res.ok    = ok;
    res.value = ok ? value : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ipv4p_pkg::PH_START;
      base       <= ipv4p_pkg::BASE_DEC;
      acc        <= '0;
      parts_done <= 2'd0;
      error_seen <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      base       <= base_next;
      acc        <= acc_next;
      parts_done <= parts_done_next;
      error_seen <= error_seen_next;
    end
  end

  // leading part bytes are written before they are read
  always_ff @(posedge clk) begin
    if (step && lp_we) begin
      leading_parts[parts_done] <= acc[7:0];
    end
  end

  a_error_flag : assert property (@(posedge clk) disable iff (rst)
    (phase == ipv4p_pkg::PH_ERROR) |-> error_seen)
    else $error("error phase without error flag");

  a_clear_after_finish : assert property (@(posedge clk) disable iff (rst)
    (step && res.fire) |=> (phase == ipv4p_pkg::PH_START) && (parts_done == 2'd0) &&
                           (acc == 33'd0) && !error_seen)
    else $error("parser state not cleared after terminator");

  a_acc_saturates : assert property (@(posedge clk) disable iff (rst)
    acc[32] |-> (acc[31:0] == 32'd0))
    else $error("accumulator beyond saturation value");

endmodule

### hdl/ipv4p_result_reg.sv
// output register holding one parsed address until it is taken
module ipv4p_result_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ipv4p_pkg::result_t  res,
  input  logic                result_stall,
  output logic                result_valid,
  output logic                address_valid,
  output logic [31:0]         address_value,
  output logic                room
);

  // room for a new result this cycle: empty, or the held one leaves now
  assign room = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      address_valid <= res.ok;
      address_value <= res.value;
    end
  end

endmodule

### hdl/ipv4_dotted_text_parser_top.sv
// top level of the ipv4 dotted text parser: input register, parse core, result register
//
//  channel   direction  handshake                 payload
//  char      in         char_valid / char_stall   character[7:0]
//  result    out        result_valid / result_stall  address_valid, address_value[31:0]
//
// one character per cycle while char_stall is low; a result is presented once its accepted
//   terminator has passed the input register to the core and the core has loaded the result register
// the whole per-character update is one shift-and-add on the 33-bit part accumulator
// rst is synchronous: parser returns to the start of a part, no result pending
// result_stall only holds back a terminator while the previous result still waits;
//   ordinary characters keep flowing past a waiting result
module ipv4_dotted_text_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  character,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        address_valid,
  output logic [31:0] address_value
);

  // input register
  logic       q_valid;
  logic [7:0] q_char;

  ipv4p_pkg::result_t res;
  logic               room;
  logic               proc;
  logic               accept;
  logic               load;

  // the held character is processed unless it is a terminator with no room
  assign proc       = q_valid && (!res.fire || room);
  assign char_stall = q_valid && !proc;
  assign accept     = char_valid && !char_stall;
  assign load       = proc && res.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (proc) begin
      q_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      q_char <= character;
    end
  end

  ipv4p_parse_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (proc),
    .ch   (q_char),
    .res  (res)
  );

  ipv4p_result_reg u_result (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .res           (res),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .address_valid (address_valid),
    .address_value (address_value),
    .room          (room)
  );

  a_invalid_is_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !address_valid) |-> (address_value == 32'd0))
    else $error("invalid address transaction carries a nonzero value");

  a_load_shows : assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid)
    else $error("terminator processed but no result transaction pending");

  a_held_char_kept : assert property (@(posedge clk) disable iff (rst)
    (q_valid && !proc) |=> (q_valid && $stable(q_char)))
    else $error("stalled character lost from input register");

endmodule

### dv/address_parse_checker.sv
`timescale 1ns / 1ps
// checker for the ipv4 dotted text parser: predicts addresses from characters and compares
module address_parse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [7:0]  character,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        address_valid,
  input  logic [31:0] address_value,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } address_t;

  address_t    expected_q[$];

  // predicted parser state
  ipv4p_pkg::phase_t phase;
  ipv4p_pkg::base_t  base;
  logic [32:0] part_acc;
  logic [1:0]  parts;
  logic [7:0]  lead [3];
  logic        err;
  int          fails;

  initial begin
    fails = 0;
  end

  task automatic clear_parse();
    phase    = ipv4p_pkg::PH_START;
    base     = ipv4p_pkg::BASE_DEC;
    part_acc = '0;
    parts    = '0;
    lead[0]  = '0;
    lead[1]  = '0;
    lead[2]  = '0;
    err      = 1'b0;
  endtask

  task automatic flag_error();
    err   = 1'b1;
    phase = ipv4p_pkg::PH_ERROR;
  endtask

  // terminator: queue the expected address and start over
  task automatic emit_address();
    address_t    r;
    logic [32:0] limit;
    case (parts)
      2'd0:    limit = ipv4p_pkg::LIMIT_ONE_PART;
      2'd1:    limit = ipv4p_pkg::LIMIT_TWO_PART;
      2'd2:    limit = ipv4p_pkg::LIMIT_THREE_PART;
      default: limit = ipv4p_pkg::LIMIT_FOUR_PART;
    endcase
    r.ok    = !err && (phase != ipv4p_pkg::PH_ERROR) && (part_acc <= limit);
    r.value = part_acc[31:0];
    if (parts >= 2'd1) r.value = r.value | {lead[0], 24'd0};
    if (parts >= 2'd2) r.value = r.value | {8'd0, lead[1], 16'd0};
    if (parts >= 2'd3) r.value = r.value | {16'd0, lead[2], 8'd0};
    if (!r.ok) r.value = '0;
    expected_q.push_back(r);
    clear_parse();
  endtask

  task automatic parse_char(input logic [7:0] ch);
    logic        is_digit;
    logic        in_part;
    logic        has_value;
    logic [3:0]  dval;
    logic [4:0]  mult;
    logic [39:0] next;
    is_digit = (ch >= ipv4p_pkg::CHAR_0) && (ch <= ipv4p_pkg::CHAR_9);
    in_part  = 1'b0;
    case (phase)
      ipv4p_pkg::PH_START: begin
        if (!is_digit) begin
          flag_error();
          if (ch == ipv4p_pkg::CHAR_NUL) emit_address();
        end else begin
          part_acc = '0;
          if (ch == ipv4p_pkg::CHAR_0) begin
            phase = ipv4p_pkg::PH_ZERO;
          end else begin
            base     = ipv4p_pkg::BASE_DEC;
            part_acc = 33'(ch - ipv4p_pkg::CHAR_0);
            phase    = ipv4p_pkg::PH_DIGITS;
          end
        end
      end
      ipv4p_pkg::PH_ZERO: begin
        phase = ipv4p_pkg::PH_DIGITS;
        if (ch == ipv4p_pkg::CHAR_LX || ch == ipv4p_pkg::CHAR_UX) begin
          base = ipv4p_pkg::BASE_HEX;
        end else begin
          base    = ipv4p_pkg::BASE_OCT;
          in_part = 1'b1;
        end
      end
      ipv4p_pkg::PH_DIGITS: in_part = 1'b1;
      // trailing text and error phases only wait for the terminator
      default: if (ch == ipv4p_pkg::CHAR_NUL) emit_address();
    endcase

    if (in_part) begin
      has_value = 1'b1;
      dval      = '0;
      case (base)
        ipv4p_pkg::BASE_OCT: mult = 5'd8;
        ipv4p_pkg::BASE_HEX: mult = 5'd16;
        default:             mult = 5'd10;
      endcase
      if (is_digit)
        dval = 4'(ch - ipv4p_pkg::CHAR_0);
      else if (base == ipv4p_pkg::BASE_HEX && ch >= ipv4p_pkg::CHAR_LA &&
               ch <= ipv4p_pkg::CHAR_LF)
        dval = 4'(ch - ipv4p_pkg::CHAR_LA + 8'd10);
      else if (base == ipv4p_pkg::BASE_HEX && ch >= ipv4p_pkg::CHAR_UA &&
               ch <= ipv4p_pkg::CHAR_UF)
        dval = 4'(ch - ipv4p_pkg::CHAR_UA + 8'd10);
      else
        has_value = 1'b0;

      if (has_value) begin
        // octal parts take 8 and 9 as digits too; accumulator saturates
        next     = 40'(part_acc) * mult + dval;
        part_acc = (next >= 40'(ipv4p_pkg::ACC_SAT)) ? ipv4p_pkg::ACC_SAT : next[32:0];
      end else if (ch == ipv4p_pkg::CHAR_DOT) begin
        if (parts == 2'd3 || part_acc > ipv4p_pkg::LIMIT_FOUR_PART) begin
          flag_error();
        end else begin
          lead[parts] = part_acc[7:0];
          parts       = parts + 2'd1;
          part_acc    = '0;
          base        = ipv4p_pkg::BASE_DEC;
          phase       = ipv4p_pkg::PH_START;
        end
      end else if (ch == ipv4p_pkg::CHAR_NUL) begin
        emit_address();
      end else if (ch == ipv4p_pkg::CHAR_SPACE ||
                   (ch >= ipv4p_pkg::CHAR_TAB && ch <= ipv4p_pkg::CHAR_CR)) begin
        phase = ipv4p_pkg::PH_IGNORE;
      end else begin
        flag_error();
      end
    end
  endtask

  // results are taken before characters so a result never meets its own terminator
  always @(posedge clk) begin : watch
    address_t want;
    if (rst) begin
      clear_parse();
      expected_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $error("address result with none expected: address_valid %0d, address_value %h",
                 address_valid, address_value);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (address_valid !== want.ok) begin
            $error("address_valid: expected %0d, actual %0d", want.ok, address_valid);
            fails++;
          end
          if (address_value !== want.value) begin
            $error("address_value: expected %h, actual %h", want.value, address_value);
            fails++;
          end
        end
      end
      if (char_valid && !char_stall) parse_char(character);
    end
    mismatch_count  <= fails;
    pending_results <= expected_q.size();
  end

endmodule

### dv/ipv4_dotted_text_parser_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the ipv4 dotted text parser: character stimulus, result sink and verdict
module ipv4_dotted_text_parser_top_tb;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_CHARS = 1100;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst          = 1'b1;
  logic        char_valid   = 1'b0;
  logic        char_stall;
  logic [7:0]  character    = 8'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        address_valid;
  logic [31:0] address_value;

  int          mismatch_count;
  int          pending_results;
  int          cycle_count  = 0;
  logic        hold_request = 1'b0;

  // text of the strings waiting to go out, terminators included
  logic [7:0]  text_q[$];
  int          ignored_chars;
  int          burst_left   = 0;

  ipv4_dotted_text_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .character     (character),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .address_valid (address_valid),
    .address_value (address_value)
  );

  address_parse_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_stall      (char_stall),
    .character       (character),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .address_valid   (address_valid),
    .address_value   (address_value),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case the handshake hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result sink: one long hold-off when asked, otherwise segments of
  // no stall, light stall, heavy stall or a fixed periodic pattern
  initial begin : result_sink
    int mode;
    int seg_left;
    int hold_left;
    bit hold_taken;
    mode       = 0;
    seg_left   = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD - 1;
        result_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  // append one string plus its terminator
  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    text_q.push_back(ipv4p_pkg::CHAR_NUL);
  endtask

  // digits of a value in the given radix, hex letters in random case
  task automatic add_number(input logic [39:0] val, input int radix);
    logic [7:0]  digits[$];
    logic [39:0] rest;
    int          d;
    rest = val;
    do begin
      d = int'(rest % radix);
      if (d < 10)
        digits.push_front(8'(ipv4p_pkg::CHAR_0 + d));
      else
        digits.push_front(8'(($urandom_range(0, 1) ? ipv4p_pkg::CHAR_LA
                                                   : ipv4p_pkg::CHAR_UA) + d - 10));
      rest = rest / radix;
    end while (rest != 0);
    foreach (digits[i]) text_q.push_back(digits[i]);
  endtask

  // one part; values cluster on the limit, just past it, zero and overflow
  task automatic add_part(input logic [32:0] limit);
    logic [39:0] val;
    case ($urandom_range(0, 7))
      0:       val = '0;
      1:       val = 40'(limit);
      2:       val = 40'(limit) + 40'd1;
      3:       val = {8'd0, 32'($urandom())};
      4:       val = 40'hFF_FFFF_FFFF >> $urandom_range(0, 12);
      default: val = {8'd0, 32'($urandom_range(0, limit[31:0]))};
    endcase
    case ($urandom_range(0, 9))
      6: begin
        text_q.push_back(ipv4p_pkg::CHAR_0);
        add_number(val, 8);
      end
      7, 8: begin
        text_q.push_back(ipv4p_pkg::CHAR_0);
        text_q.push_back($urandom_range(0, 1) ? ipv4p_pkg::CHAR_LX : ipv4p_pkg::CHAR_UX);
        // now and then a bare 0x
        if ($urandom_range(0, 7) != 0) add_number(val, 16);
      end
      // free digit run: octal with 8 and 9, and long overflowing numbers
      9: repeat ($urandom_range(1, 14))
           text_q.push_back(8'($urandom_range(ipv4p_pkg::CHAR_0, ipv4p_pkg::CHAR_9)));
      default: add_number(val, 10);
    endcase
  endtask

  // mostly well formed addresses, some with one character spoiled, some noise
  task automatic build_text();
    int          kind;
    int          n_parts;
    int          pos;
    logic [32:0] last_limit;
    ignored_chars = 0;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      repeat ($urandom_range(0, 10)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      // five parts now and then, for the too-many-dots case
      n_parts = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
      case (n_parts)
        1:       last_limit = ipv4p_pkg::LIMIT_ONE_PART;
        2:       last_limit = ipv4p_pkg::LIMIT_TWO_PART;
        3:       last_limit = ipv4p_pkg::LIMIT_THREE_PART;
        default: last_limit = ipv4p_pkg::LIMIT_FOUR_PART;
      endcase
      for (int i = 1; i < n_parts; i++) begin
        add_part(ipv4p_pkg::LIMIT_FOUR_PART);
        text_q.push_back(ipv4p_pkg::CHAR_DOT);
      end
      add_part(last_limit);
      if ($urandom_range(0, 29) == 0) text_q.push_back(ipv4p_pkg::CHAR_DOT);
      // whitespace, then junk that the parser skips
      if ($urandom_range(0, 4) == 0) begin
        text_q.push_back(($urandom_range(0, 6) == 6) ? ipv4p_pkg::CHAR_SPACE :
                         8'($urandom_range(ipv4p_pkg::CHAR_TAB, ipv4p_pkg::CHAR_CR)));
        ignored_chars = $urandom_range(0, 5);
        repeat (ignored_chars) text_q.push_back(8'($urandom_range(1, 255)));
      end
      if (kind >= 70) begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = 8'($urandom_range(1, 255));
      end
    end
    text_q.push_back(ipv4p_pkg::CHAR_NUL);
  endtask

  // sends the queued text in bursts; called and returns at a rising edge
  task automatic send_text();
    int gap;
    while (text_q.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          char_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        // mostly short bursts, sometimes a long unbroken run
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      char_valid <= 1'b1;
      character  <= text_q.pop_front();
      // stall is settled by the falling edge; the next rising edge takes the transaction
      @(negedge clk);
      while (char_stall) @(negedge clk);
      @(posedge clk);
    end
  endtask

  // sender goes quiet until every expected address has come back
  task automatic wait_drained();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int  useful;
    bit  mid_pause_done;
    useful         = 0;
    mid_pause_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed strings: empty, bare 0x, octal 8 with a trailing dot,
    // hex in both cases with whitespace and a non-ascii char skipped,
    // non-ascii char inside a part, leading part too large, too many dots
    push_string("");
    push_string("0x");
    push_string("08.");
    push_string("0XfF.1\t\377");
    push_string("9\377");
    push_string("300.1");
    push_string("1.2.3.4.");
    send_text();
    wait_drained();

    // random strings; the sink takes its long hold-off early so
    // terminators back up and the input gets stalled
    hold_request <= 1'b1;
    while (useful < RANDOM_CHARS) begin
      build_text();
      useful += text_q.size() - ignored_chars;
      send_text();
      if (!mid_pause_done && useful >= RANDOM_CHARS / 2) begin
        mid_pause_done = 1'b1;
        wait_drained();
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
hdl/ipv4p_pkg.sv
hdl/ipv4p_parse_core.sv
hdl/ipv4p_result_reg.sv
hdl/ipv4_dotted_text_parser_top.sv
dv/address_parse_checker.sv
dv/ipv4_dotted_text_parser_top_tb.sv
